/* hw/rtl/amie_pkg.sv */
// Shared types and constants for the accumulator MCU instruction execute block.
package amie_pkg;

	typedef enum logic [5:0] {
		OP_ADDWF  = 6'd0,  OP_ANDWF  = 6'd1,  OP_CLRF   = 6'd2,  OP_CLRW   = 6'd3,
		OP_COMF   = 6'd4,  OP_DECF   = 6'd5,  OP_DECFSZ = 6'd6,  OP_INCF   = 6'd7,
		OP_INCFSZ = 6'd8,  OP_IORWF  = 6'd9,  OP_MOVF   = 6'd10, OP_MOVWF  = 6'd11,
		OP_NOP    = 6'd12, OP_RLF    = 6'd13, OP_RRF    = 6'd14, OP_SUBWF  = 6'd15,
		OP_SWAPF  = 6'd16, OP_XORWF  = 6'd17, OP_BCF    = 6'd18, OP_BSF    = 6'd19,
		OP_BTFSC  = 6'd20, OP_BTFSS  = 6'd21, OP_ADDLW  = 6'd22, OP_ANDLW  = 6'd23,
		OP_CLRWDT = 6'd24, OP_IORLW  = 6'd25, OP_MOVLW  = 6'd26, OP_SUBLW  = 6'd27,
		OP_XORLW  = 6'd28, OP_RETLW  = 6'd29, OP_CALL   = 6'd30, OP_GOTO   = 6'd31,
		OP_RETFIE = 6'd32, OP_RETURN = 6'd33, OP_SLEEP  = 6'd34
	} op_t;

	localparam logic [6:0] ADDR_INDF   = 7'd0;
	localparam logic [6:0] ADDR_STATUS = 7'd3;
	localparam logic [6:0] ADDR_FSR    = 7'd4;

	localparam logic [2:0] FLAG_C    = 3'b001;
	localparam logic [2:0] FLAG_DC   = 3'b010;
	localparam logic [2:0] FLAG_Z    = 3'b100;
	localparam logic [2:0] FLAG_ALL  = 3'b111;
	localparam logic [3:0] NIBBLE    = 4'hF;

	typedef struct packed {
		logic [5:0]  cmd;
		logic [6:0]  file_addr;
		logic        dest_to_file;
		logic [2:0]  bit_index;
		logic [7:0]  literal;
		logic [10:0] jump_target;
	} instr_t;

	typedef struct packed {
		logic [12:0] pc_next;
		logic [7:0]  w_value;
		logic [2:0]  flags;
		logic        reg_written;
		logic [7:0]  reg_addr;
		logic [7:0]  reg_data;
		logic        skipped;
	} result_t;

	// Classified instruction as it sits in the queue between front and back.
	typedef struct packed {
		op_t         op;
		logic [6:0]  file_addr;
		logic        dest_to_file;
		logic [2:0]  bit_index;
		logic [7:0]  literal;
		logic [10:0] jump_target;
	} entry_t;

	// Queue handshake toward the back end.
	typedef struct packed {
		logic   empty;
		entry_t head;
	} q_status_t;

endpackage

/* hw/rtl/amie_front.sv */
// Front end: accepts instructions, classifies the opcode and queues them.
module amie_front
	import amie_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  instr_t    instr,
	output q_status_t q_status,
	input  logic      q_pop
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	entry_t     decoded;
	logic       do_push;
	logic       do_pop;

	// Codes past the last instruction, and the sleep/watchdog/interrupt
	// returns, all collapse to NOP.
	always_comb begin
		decoded.file_addr    = instr.file_addr;
		decoded.dest_to_file = instr.dest_to_file;
		decoded.bit_index    = instr.bit_index;
		decoded.literal      = instr.literal;
		decoded.jump_target  = instr.jump_target;
		if (instr.cmd > OP_SLEEP) begin
			decoded.op = OP_NOP;
		end else begin
			decoded.op = op_t'(instr.cmd);
		end
		if (decoded.op == OP_CLRWDT || decoded.op == OP_RETFIE || decoded.op == OP_SLEEP) begin
			decoded.op = OP_NOP;
		end
	end

	assign full           = (count_q == 2'd2);
	assign do_push        = push && !full;
	assign do_pop         = q_pop && (count_q != 2'd0);
	assign q_status.empty = (count_q == 2'd0);
	assign q_status.head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* hw/rtl/amie_back.sv */
// Back end: register file, W, STATUS, return stack and instruction execution.
module amie_back
	import amie_pkg::*;
#(
	parameter int REG_FILE_DEPTH = 256,
	parameter int STACK_DEPTH    = 8,
	parameter int PC_WIDTH       = 13
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output result_t   result
);

	localparam int AW = $clog2(REG_FILE_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_FETCH = 2'b01,
		S_EXEC  = 2'b10
	} state_t;

	state_t                state_q;
	logic [7:0]            mem [REG_FILE_DEPTH];
	logic [REG_FILE_DEPTH-1:0] valid_q;
	logic [7:0]            w_q;
	logic [7:0]            status_q;
	logic [7:0]            fsr_q;
	logic [PC_WIDTH-1:0]   pc_q;
	logic [PC_WIDTH-1:0]   stack_q [STACK_DEPTH];
	logic [SW-1:0]         sp_q;

	entry_t                item_s1;
	logic [AW-1:0]         eff_s1;
	logic [7:0]            rd_s1;
	logic                  vld_s1;

	result_t               res_q;
	logic                  out_valid_q;

	// Effective address for the head of the queue.
	logic [8:0]            fsr_wrap;
	logic [AW-1:0]         eff;

	always_comb begin
		fsr_wrap = {1'b0, fsr_q} - 9'(REG_FILE_DEPTH);
		if (q_status.head.file_addr != ADDR_INDF) begin
			eff = AW'(q_status.head.file_addr);
		end else if ({1'b0, fsr_q} >= 9'(REG_FILE_DEPTH)) begin
			eff = fsr_wrap[AW-1:0];
		end else begin
			eff = AW'(fsr_q);
		end
	end

	assign q_pop = (state_q == S_FETCH) && !q_status.empty;

	// Execute
	logic                exec_go;
	logic [7:0]          fv;
	logic [7:0]          t;
	logic [8:0]          sum9;
	logic [4:0]          nib_sum;
	logic [7:0]          res;
	logic [2:0]          fmask;
	logic [2:0]          nf;
	logic                wr_file;
	logic                wr_w;
	logic                skip;
	logic                written;
	logic [7:0]          v;
	logic [7:0]          s_new;
	logic [7:0]          bmask;
	logic [PC_WIDTH-1:0] pc1;
	logic [PC_WIDTH-1:0] pc_fin;
	logic [SW-1:0]       sp_inc;
	logic [SW-1:0]       sp_dec;
	logic                is_status;
	logic                is_fsr;

	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || pop);
	assign is_status = (eff_s1 == AW'(ADDR_STATUS));
	assign is_fsr    = (eff_s1 == AW'(ADDR_FSR));
	assign pc1       = pc_q + 1'b1;
	assign sp_inc    = (sp_q == SW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec    = (sp_q == '0) ? SW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign bmask     = 8'd1 << item_s1.bit_index;

	always_comb begin
		if (eff_s1 == AW'(ADDR_INDF))  fv = 8'd0;
		else if (is_status)            fv = status_q;
		else if (is_fsr)               fv = fsr_q;
		else if (vld_s1)               fv = rd_s1;
		else                           fv = 8'd0;

		t       = (item_s1.op == OP_ADDWF || item_s1.op == OP_SUBWF) ? fv : item_s1.literal;
		sum9    = {1'b0, t} + {1'b0, w_q};
		nib_sum = {1'b0, t[3:0]} + {1'b0, w_q[3:0]};
		res     = 8'd0;
		fmask   = 3'b000;
		nf      = 3'b000;
		wr_file = 1'b0;
		wr_w    = 1'b0;
		skip    = 1'b0;
		pc_fin  = pc1;

		unique case (item_s1.op)
			OP_ADDWF, OP_ADDLW: begin
				res   = sum9[7:0];
				fmask = FLAG_ALL;
				if (sum9[8])    nf = nf | FLAG_C;
				if (nib_sum[4]) nf = nf | FLAG_DC;
				if (item_s1.op == OP_ADDWF) begin
					wr_file = item_s1.dest_to_file;
					wr_w    = !item_s1.dest_to_file;
				end else begin
					wr_w = 1'b1;
				end
			end
			OP_SUBWF, OP_SUBLW: begin
				res   = t - w_q;
				fmask = FLAG_ALL;
				if (t >= w_q)                         nf = nf | FLAG_C;
				if ((t & {4'h0, NIBBLE}) >= (w_q & {4'h0, NIBBLE})) nf = nf | FLAG_DC;
				if (item_s1.op == OP_SUBWF) begin
					wr_file = item_s1.dest_to_file;
					wr_w    = !item_s1.dest_to_file;
				end else begin
					wr_w = 1'b1;
				end
			end
			OP_ANDWF, OP_COMF, OP_DECF, OP_INCF, OP_IORWF, OP_MOVF, OP_XORWF: begin
				case (item_s1.op)
					OP_ANDWF: res = w_q & fv;
					OP_COMF:  res = ~fv;
					OP_DECF:  res = fv - 8'd1;
					OP_INCF:  res = fv + 8'd1;
					OP_IORWF: res = w_q | fv;
					OP_MOVF:  res = fv;
					default:  res = w_q ^ fv;
				endcase
				fmask   = FLAG_Z;
				wr_file = item_s1.dest_to_file;
				wr_w    = !item_s1.dest_to_file;
			end
			OP_CLRF: begin
				fmask   = FLAG_Z;
				wr_file = 1'b1;
			end
			OP_CLRW: begin
				fmask = FLAG_Z;
				wr_w  = 1'b1;
			end
			OP_DECFSZ, OP_INCFSZ: begin
				res     = (item_s1.op == OP_DECFSZ) ? fv - 8'd1 : fv + 8'd1;
				wr_file = item_s1.dest_to_file;
				wr_w    = !item_s1.dest_to_file;
				skip    = (res == 8'd0);
			end
			OP_MOVWF: begin
				res     = w_q;
				wr_file = 1'b1;
			end
			OP_RLF: begin
				res     = {fv[6:0], status_q[0]};
				fmask   = FLAG_C;
				nf      = {2'b00, fv[7]};
				wr_file = item_s1.dest_to_file;
				wr_w    = !item_s1.dest_to_file;
			end
			OP_RRF: begin
				res     = {status_q[0], fv[7:1]};
				fmask   = FLAG_C;
				nf      = {2'b00, fv[0]};
				wr_file = item_s1.dest_to_file;
				wr_w    = !item_s1.dest_to_file;
			end
			OP_SWAPF: begin
				res     = {fv[3:0], fv[7:4]};
				wr_file = item_s1.dest_to_file;
				wr_w    = !item_s1.dest_to_file;
			end
			OP_BCF: begin
				res     = fv & ~bmask;
				wr_file = 1'b1;
			end
			OP_BSF: begin
				res     = fv | bmask;
				wr_file = 1'b1;
			end
			OP_BTFSC: skip = ((fv & bmask) == 8'd0);
			OP_BTFSS: skip = ((fv & bmask) != 8'd0);
			OP_ANDLW, OP_IORLW, OP_XORLW: begin
				case (item_s1.op)
					OP_ANDLW: res = w_q & item_s1.literal;
					OP_IORLW: res = w_q | item_s1.literal;
					default:  res = w_q ^ item_s1.literal;
				endcase
				fmask = FLAG_Z;
				wr_w  = 1'b1;
			end
			OP_MOVLW: begin
				res  = item_s1.literal;
				wr_w = 1'b1;
			end
			OP_RETLW, OP_RETURN: begin
				if (item_s1.op == OP_RETLW) begin
					res  = item_s1.literal;
					wr_w = 1'b1;
				end
				pc_fin = stack_q[sp_dec];
			end
			OP_CALL, OP_GOTO: pc_fin = PC_WIDTH'(item_s1.jump_target);
			default: ;
		endcase

		if (fmask != 3'b000 && res == 8'd0) nf = nf | (fmask & FLAG_Z);

		written = wr_file && (eff_s1 != AW'(ADDR_INDF));
		v       = res;
		if (is_status && fmask != 3'b000) v = {res[7:3], status_q[2:0]};
		s_new   = (written && is_status) ? v : status_q;
		s_new   = {s_new[7:3], (s_new[2:0] & ~fmask) | (nf & fmask)};
		if (skip) pc_fin = pc_fin + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_status.head;
			eff_s1  <= eff;
			rd_s1   <= mem[eff];
		end
		if (exec_go && written) begin
			mem[eff_s1] <= v;
		end
		if (exec_go && item_s1.op == OP_CALL) begin
			stack_q[sp_q] <= pc1;
		end
		if (exec_go) begin
			res_q.pc_next     <= 13'(pc_fin);
			res_q.w_value     <= wr_w ? res : w_q;
			res_q.flags       <= s_new[2:0];
			res_q.reg_written <= written;
			res_q.reg_addr    <= written ? 8'(eff_s1) : 8'd0;
			res_q.reg_data    <= written ? (is_status ? s_new : v) : 8'd0;
			res_q.skipped     <= skip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FETCH;
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			w_q         <= 8'd0;
			status_q    <= 8'd0;
			fsr_q       <= 8'd0;
			pc_q        <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go)  out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				S_FETCH: begin
					if (q_pop) begin
						vld_s1  <= valid_q[eff];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q     <= S_FETCH;
						pc_q        <= pc_fin;
						status_q    <= s_new;
						if (wr_w) w_q <= res;
						if (written) valid_q[eff_s1] <= 1'b1;
						if (written && is_fsr) fsr_q <= v;
						if (item_s1.op == OP_CALL) sp_q <= sp_inc;
						if (item_s1.op == OP_RETLW || item_s1.op == OP_RETURN) sp_q <= sp_dec;
					end
				end
				default: state_q <= S_FETCH;
			endcase
		end
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

/* hw/rtl/accumulator_mcu_instruction_execute.sv */
// Top level of the accumulator MCU instruction execute block.
// A transaction goes through the queue, the operand read register and the result register.
// The back end takes one transaction at a time: register file read state, then execute state.
// A two-entry instruction queue takes new transactions while the back end works or stalls.
// Reset (arst_n low) clears W, STATUS, FSR, PC, stack pointer, queues and the
// register file valid bits at once; no clearing pass is needed.
module accumulator_mcu_instruction_execute
	import amie_pkg::*;
#(
	parameter int REG_FILE_DEPTH = 256,
	parameter int STACK_DEPTH    = 8,
	parameter int PC_WIDTH       = 13
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  instr_t  instr,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	q_status_t q_status;
	logic      q_pop;

	// Front: accept and classify, queue up to two transactions.
	amie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.instr    (instr),
		.q_status (q_status),
		.q_pop    (q_pop)
	);

	// Back: read operand, execute, write back, hold result in output register.
	amie_back #(
		.REG_FILE_DEPTH (REG_FILE_DEPTH),
		.STACK_DEPTH    (STACK_DEPTH),
		.PC_WIDTH       (PC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* hw/rtl/amie_checker.sv */
// Port-level checker for the instruction execute block, with its bind.
module amie_checker
	import amie_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    full,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	a_out_of_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("block not idle after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.reg_written) |-> (result.reg_addr == 8'd0 && result.reg_data == 8'd0))
		else $error("address or data set without a write");

	a_write_not_indf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.reg_written) |-> (result.reg_addr != 8'd0))
		else $error("write reported to INDF");

endmodule

bind accumulator_mcu_instruction_execute amie_checker u_amie_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

/* verif/tb_accumulator_mcu_instruction_execute.sv */
// Testbench for the accumulator MCU instruction execute block: directed table plus random program.
module tb_accumulator_mcu_instruction_execute;
	timeunit 1ns;
	timeprecision 1ps;
	import amie_pkg::*;

	localparam int FILE_DEPTH  = 256;
	localparam int STK_DEPTH   = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 20;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	instr_t  instr;
	logic    empty;
	logic    pop;
	result_t result;

	accumulator_mcu_instruction_execute uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .instr(instr),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor state: a shadow copy of the machine.
	logic [7:0]  mcu_regs [FILE_DEPTH];
	logic [7:0]  mcu_w;
	logic [12:0] mcu_pc;
	logic [12:0] mcu_stack [STK_DEPTH];
	logic [2:0]  mcu_sp;
	int          stack_fill;	// entries pushed and not yet popped, capped at depth

	result_t expected_results [$];
	int      errors;
	int      idle_cycles;

	// Idling knobs, percent.
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	// Execute one instruction on the shadow machine and return what the block should report.
	function automatic result_t execute_instr(instr_t in);
		result_t     r;
		logic [7:0]  eff, fv, w, old, res, v, bm;
		logic [2:0]  fmask, nf;
		logic [8:0]  sum;
		logic        wr_f, wr_w, skip;
		logic [12:0] pc;
		eff = (in.file_addr == ADDR_INDF) ? mcu_regs[ADDR_FSR] : {1'b0, in.file_addr};
		fv = (eff == 8'd0) ? 8'd0 : mcu_regs[eff];
		w = mcu_w;
		old = mcu_regs[ADDR_STATUS];
		bm = 8'd1 << in.bit_index;
		res = '0; fmask = '0; nf = '0;
		wr_f = 1'b0; wr_w = 1'b0; skip = 1'b0;
		pc = mcu_pc + 13'd1;
		case (in.cmd)
			OP_ADDWF, OP_ADDLW: begin
				v = (in.cmd == OP_ADDWF) ? fv : in.literal;
				sum = v + w;
				res = sum[7:0];
				fmask = FLAG_ALL;
				if (sum[8]) nf |= FLAG_C;
				if ({1'b0, v[3:0]} + {1'b0, w[3:0]} > 5'd15) nf |= FLAG_DC;
				if (in.cmd == OP_ADDWF) begin wr_f = in.dest_to_file; wr_w = !in.dest_to_file; end
				else wr_w = 1'b1;
			end
			OP_SUBWF, OP_SUBLW: begin
				v = (in.cmd == OP_SUBWF) ? fv : in.literal;
				res = v - w;
				fmask = FLAG_ALL;
				if (v >= w) nf |= FLAG_C;
				if (v[3:0] >= w[3:0]) nf |= FLAG_DC;
				if (in.cmd == OP_SUBWF) begin wr_f = in.dest_to_file; wr_w = !in.dest_to_file; end
				else wr_w = 1'b1;
			end
			OP_ANDWF, OP_COMF, OP_DECF, OP_INCF, OP_IORWF, OP_MOVF, OP_XORWF: begin
				case (in.cmd)
					OP_ANDWF: res = w & fv;
					OP_COMF:  res = ~fv;
					OP_DECF:  res = fv - 8'd1;
					OP_INCF:  res = fv + 8'd1;
					OP_IORWF: res = w | fv;
					OP_MOVF:  res = fv;
					default:  res = w ^ fv;
				endcase
				fmask = FLAG_Z;
				wr_f = in.dest_to_file; wr_w = !in.dest_to_file;
			end
			OP_CLRF: begin fmask = FLAG_Z; wr_f = 1'b1; end
			OP_CLRW: begin fmask = FLAG_Z; wr_w = 1'b1; end
			OP_DECFSZ, OP_INCFSZ: begin
				res = (in.cmd == OP_DECFSZ) ? fv - 8'd1 : fv + 8'd1;
				wr_f = in.dest_to_file; wr_w = !in.dest_to_file;
				skip = (res == 8'd0);
			end
			OP_MOVWF: begin res = w; wr_f = 1'b1; end
			OP_RLF: begin
				res = {fv[6:0], old[0]};
				fmask = FLAG_C; nf = {2'b00, fv[7]};
				wr_f = in.dest_to_file; wr_w = !in.dest_to_file;
			end
			OP_RRF: begin
				res = {old[0], fv[7:1]};
				fmask = FLAG_C; nf = {2'b00, fv[0]};
				wr_f = in.dest_to_file; wr_w = !in.dest_to_file;
			end
			OP_SWAPF: begin
				res = {fv[3:0], fv[7:4]};
				wr_f = in.dest_to_file; wr_w = !in.dest_to_file;
			end
			OP_BCF: begin res = fv & ~bm; wr_f = 1'b1; end
			OP_BSF: begin res = fv | bm; wr_f = 1'b1; end
			OP_BTFSC: skip = ((fv & bm) == 8'd0);
			OP_BTFSS: skip = ((fv & bm) != 8'd0);
			OP_ANDLW, OP_IORLW, OP_XORLW: begin
				res = (in.cmd == OP_ANDLW) ? (w & in.literal) :
					(in.cmd == OP_IORLW) ? (w | in.literal) : (w ^ in.literal);
				fmask = FLAG_Z; wr_w = 1'b1;
			end
			OP_MOVLW: begin res = in.literal; wr_w = 1'b1; end
			OP_RETLW, OP_RETURN: begin
				if (in.cmd == OP_RETLW) begin res = in.literal; wr_w = 1'b1; end
				mcu_sp = mcu_sp - 3'd1;
				pc = mcu_stack[mcu_sp];
				stack_fill--;
			end
			OP_CALL: begin
				mcu_stack[mcu_sp] = pc;
				mcu_sp = mcu_sp + 3'd1;
				pc = {2'b00, in.jump_target};
				if (stack_fill < STK_DEPTH) stack_fill++;
			end
			OP_GOTO: pc = {2'b00, in.jump_target};
			default: ;	// NOP, CLRWDT, RETFIE, SLEEP and unused codes
		endcase
		if (fmask != 3'd0 && res == 8'd0) nf |= (fmask & FLAG_Z);
		if (wr_w) mcu_w = res;
		r = '0;
		if (wr_f && eff != 8'd0) begin
			v = res;
			// flag write wins over the result when STATUS is the target
			if (eff == ADDR_STATUS && fmask != 3'd0) v = {res[7:3], old[2:0]};
			mcu_regs[eff] = v;
			r.reg_written = 1'b1;
			r.reg_addr = eff;
		end
		if (fmask != 3'd0)
			mcu_regs[ADDR_STATUS][2:0] = (mcu_regs[ADDR_STATUS][2:0] & ~fmask) | (nf & fmask);
		if (skip) pc = pc + 13'd1;
		mcu_pc = pc;
		r.pc_next = pc;
		r.w_value = mcu_w;
		r.flags = mcu_regs[ADDR_STATUS][2:0];
		if (r.reg_written) r.reg_data = mcu_regs[eff];
		r.skipped = skip;
		return r;
	endfunction

	function automatic instr_t make_instr(op_t op, logic [6:0] fa, logic d, logic [2:0] b,
			logic [7:0] k, logic [10:0] j);
		instr_t i;
		i.cmd = op; i.file_addr = fa; i.dest_to_file = d;
		i.bit_index = b; i.literal = k; i.jump_target = j;
		return i;
	endfunction

	// Random instruction; send_random keeps returns from popping an entry that was never written.
	function automatic instr_t random_instr();
		instr_t i;
		int     pick;
		i = instr_t'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 4) i.cmd = 6'($urandom_range(35, 63));
		else i.cmd = 6'($urandom_range(0, 34));
		// favor a few hot registers so data flows between instructions
		pick = $urandom_range(0, 99);
		if (pick < 15) i.file_addr = ADDR_INDF;
		else if (pick < 25) i.file_addr = ADDR_STATUS;
		else if (pick < 35) i.file_addr = ADDR_FSR;
		else if (pick < 70) i.file_addr = 7'($urandom_range(5, 12));
		return i;
	endfunction

	// Directed rows; exp_valid marks rows whose result is typed in by hand.
	typedef struct {
		instr_t  ins;
		bit      exp_valid;
		result_t exp;
	} stim_row_t;

	stim_row_t directed [$];

	task automatic add_row(instr_t i, bit has_exp = 0, result_t e = '0);
		stim_row_t row;
		row.ins = i; row.exp_valid = has_exp; row.exp = e;
		directed.push_back(row);
	endtask

	task automatic build_directed();
		// right after reset: NOP only advances PC
		add_row(make_instr(OP_NOP, 7'd0, 1'b0, 3'd0, 8'd0, 11'd0), 1,
			'{pc_next: 13'd1, w_value: 8'd0, flags: 3'b000, reg_written: 1'b0,
			  reg_addr: 8'd0, reg_data: 8'd0, skipped: 1'b0});
		// MOVLW 0xFF
		add_row(make_instr(OP_MOVLW, 7'd0, 1'b0, 3'd0, 8'hFF, 11'd0), 1,
			'{pc_next: 13'd2, w_value: 8'hFF, flags: 3'b000, reg_written: 1'b0,
			  reg_addr: 8'd0, reg_data: 8'd0, skipped: 1'b0});
		// ADDLW 0x01 wraps to zero: Z, DC, C
		add_row(make_instr(OP_ADDLW, 7'd0, 1'b0, 3'd0, 8'h01, 11'd0), 1,
			'{pc_next: 13'd3, w_value: 8'h00, flags: 3'b111, reg_written: 1'b0,
			  reg_addr: 8'd0, reg_data: 8'd0, skipped: 1'b0});
		// MOVWF 127 stores zero into the top direct address
		add_row(make_instr(OP_MOVWF, 7'd127, 1'b1, 3'd7, 8'd0, 11'd0), 1,
			'{pc_next: 13'd4, w_value: 8'h00, flags: 3'b111, reg_written: 1'b1,
			  reg_addr: 8'd127, reg_data: 8'd0, skipped: 1'b0});
		// GOTO the top of the jump range
		add_row(make_instr(OP_GOTO, 7'd0, 1'b0, 3'd0, 8'd0, 11'h7FF), 1,
			'{pc_next: 13'h7FF, w_value: 8'h00, flags: 3'b111, reg_written: 1'b0,
			  reg_addr: 8'd0, reg_data: 8'd0, skipped: 1'b0});
		// remaining rows checked against the predictor
		add_row(make_instr(OP_SUBLW, 7'd0, 1'b0, 3'd0, 8'h10, 11'd0));	// borrow-free sub
		add_row(make_instr(OP_SUBLW, 7'd0, 1'b0, 3'd0, 8'h00, 11'd0));	// borrow
		add_row(make_instr(OP_MOVWF, 7'd4, 1'b1, 3'd0, 8'd0, 11'd0));	// FSR = W
		add_row(make_instr(OP_MOVLW, 7'd0, 1'b0, 3'd0, 8'hA5, 11'd0));
		add_row(make_instr(OP_MOVWF, 7'd0, 1'b1, 3'd0, 8'd0, 11'd0));	// indirect write
		add_row(make_instr(OP_ADDWF, 7'd0, 1'b1, 3'd0, 8'd0, 11'd0));	// indirect read
		add_row(make_instr(OP_CLRF, 7'd4, 1'b1, 3'd0, 8'd0, 11'd0));	// FSR = 0
		add_row(make_instr(OP_MOVWF, 7'd0, 1'b1, 3'd0, 8'd0, 11'd0));	// INDF self: dropped
		add_row(make_instr(OP_INCF, 7'd0, 1'b0, 3'd0, 8'd0, 11'd0));	// INDF self reads 0
		add_row(make_instr(OP_ADDWF, 7'd3, 1'b1, 3'd0, 8'd0, 11'd0));	// flags win on STATUS
		add_row(make_instr(OP_MOVWF, 7'd3, 1'b1, 3'd0, 8'd0, 11'd0));	// STATUS whole byte
		add_row(make_instr(OP_RLF, 7'd3, 1'b0, 3'd0, 8'd0, 11'd0));
		add_row(make_instr(OP_RRF, 7'd127, 1'b1, 3'd0, 8'd0, 11'd0));
		add_row(make_instr(OP_DECFSZ, 7'd127, 1'b1, 3'd0, 8'd0, 11'd0));
		add_row(make_instr(OP_INCFSZ, 7'd127, 1'b1, 3'd0, 8'd0, 11'd0));	// skip taken
		add_row(make_instr(OP_CALL, 7'd0, 1'b0, 3'd0, 8'd0, 11'h400));
		add_row(make_instr(OP_RETLW, 7'd0, 1'b0, 3'd0, 8'h5A, 11'd0));
		add_row(make_instr(OP_BSF, 7'd5, 1'b1, 3'd7, 8'd0, 11'd0));
		add_row(make_instr(OP_BTFSS, 7'd5, 1'b0, 3'd7, 8'd0, 11'd0));
		add_row(make_instr(OP_SWAPF, 7'd5, 1'b0, 3'd0, 8'd0, 11'd0));
	endtask

	// Send one transaction; the prediction is queued when it is accepted.
	task automatic send_instr(instr_t i, bit has_exp, result_t e);
		result_t p;
		while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		instr <= i;
		do @(posedge clk); while (full);
		p = execute_instr(i);
		if (has_exp && p != e) begin
			$display("%0t: directed row disagrees with predictor: table %p predictor %p",
				$time, e, p);
			errors++;
		end
		expected_results.push_back(has_exp ? e : p);
	endtask

	task automatic send_random(int n);
		instr_t i;
		for (int c = 0; c < n; c++) begin
			i = random_instr();
			// keep returns within what has been pushed
			if ((i.cmd == OP_RETLW || i.cmd == OP_RETURN) && stack_fill == 0)
				i.cmd = OP_CALL;
			send_instr(i, 0, '0);
		end
	endtask

	// Receiver: pops at random, checks every field against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				idle_cycles <= 0;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transaction %p", $time, result);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (result.pc_next !== e.pc_next) begin
						$display("%0t: pc_next exp %h got %h", $time, e.pc_next, result.pc_next);
						errors++;
					end
					if (result.w_value !== e.w_value) begin
						$display("%0t: w_value exp %h got %h", $time, e.w_value, result.w_value);
						errors++;
					end
					if (result.flags !== e.flags) begin
						$display("%0t: flags exp %b got %b", $time, e.flags, result.flags);
						errors++;
					end
					if (result.reg_written !== e.reg_written) begin
						$display("%0t: reg_written exp %b got %b", $time, e.reg_written,
							result.reg_written);
						errors++;
					end
					if (result.reg_addr !== e.reg_addr) begin
						$display("%0t: reg_addr exp %h got %h", $time, e.reg_addr, result.reg_addr);
						errors++;
					end
					if (result.reg_data !== e.reg_data) begin
						$display("%0t: reg_data exp %h got %h", $time, e.reg_data, result.reg_data);
						errors++;
					end
					if (result.skipped !== e.skipped) begin
						$display("%0t: skipped exp %b got %b", $time, e.skipped, result.skipped);
						errors++;
					end
				end
			end else if (push && !full) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			pop <= !hold_off && (recv_stall_pct == 0 || $urandom_range(1, 100) > recv_stall_pct);
		end
	end

	// Watchdog: no transaction in either direction for too long ends the run.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("accumulator_mcu_instruction_execute test failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		errors = 0; idle_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
		push = 1'b0; pop = 1'b0; instr = '0;
		for (int a = 0; a < FILE_DEPTH; a++) mcu_regs[a] = '0;
		mcu_w = '0; mcu_pc = '0; mcu_sp = '0; stack_fill = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		build_directed();
		foreach (directed[n]) begin
			row = directed[n];
			send_instr(row.ins, row.exp_valid, row.exp);
		end

		// random phases with different idling
		send_random(130);
		send_idle_pct = 52;
		send_random(100);
		send_idle_pct = 0; recv_stall_pct = 52;
		send_random(100);
		// long hold-off: the block fills up and stalls its input
		fork
			begin
				hold_off = 1;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			send_random(40);
		join
		send_idle_pct = 7; recv_stall_pct = 7;
		send_random(160);
		push <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("accumulator_mcu_instruction_execute test passed");
		else
			$display("accumulator_mcu_instruction_execute test failed");
		$finish;
	end

endmodule
